>>> rtl/core/dof_alloc_pkg.sv
package dof_alloc_pkg;

  // field widths of the input and result beats
  localparam int SUBSET_W = 4;
  localparam int DOFS_W   = 6;
  localparam int FIELD_W  = 24;

  // request codes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // configuration port
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int CFG_IDX_W  = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPED_MODE = 1'b0;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

endpackage

>>> rtl/core/dof_index_free_list_allocator.sv
// dof index free-list allocator
//
// input channel (in_valid / in_stall): one request beat per item; in_mode selects
// allocate or release, in_subset picks the subset counter, in_dofs_per_object
// gives the step (one in grouped mode), in_released_index is pushed on release.
// result channel (out_valid / out_stall): exactly one result beat per request,
// carrying the granted index, total used count, set size, subset count, status.
// config port (apb style, pready always high): grouped_mode at byte address 0.
//
// a request is taken into an input register together with its subset counter,
// all updates happen in one pass into the result register, which drives
// out_valid; one request per cycle is sustained while out_stall stays low.
// the top of the free stack and the entry below it are cached in registers so
// a pop needs only one read of the stack memory, to refill the entry below it.
// reset (rst_n low, synchronous) empties the stack and clears all counters and
// the subset counters at once through their valid bits: no clearing pass.
// a stalled result holds in the output register while one further request
// still enters the input register; after that in_stall is raised.
module dof_index_free_list_allocator
  import dof_alloc_pkg::*;
#(
  parameter int SUBSET_COUNT = 16,
  parameter int FREE_DEPTH   = 1024,
  parameter int INDEX_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [SUBSET_W-1:0] in_subset,
  input  logic [DOFS_W-1:0]   in_dofs_per_object,
  input  logic [FIELD_W-1:0]  in_released_index,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FIELD_W-1:0]  out_granted_index,
  output logic [FIELD_W-1:0]  out_used_total,
  output logic [FIELD_W-1:0]  out_set_size,
  output logic [FIELD_W-1:0]  out_subset_used,
  output logic [1:0]          out_status,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
  localparam int ADDR_W = $clog2(FREE_DEPTH);
  localparam int SUB_AW = (SUBSET_COUNT > 1) ? $clog2(SUBSET_COUNT) : 1;
  localparam int EXT_W  = SUB_AW + SUBSET_W;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  // configuration register
  logic                 grouped_mode_r;
  logic [CFG_IDX_W-1:0] cfg_idx;

  // input register
  logic                  in_vld_r;
  logic                  mode_r;
  logic                  sub_ok_r;
  logic [SUB_AW-1:0]     sub_addr_r;
  logic [DOFS_W-1:0]     step_r;
  logic [INDEX_BITS-1:0] rel_r;
  logic [INDEX_BITS-1:0] sub_rd_r;

  // allocator state
  logic [CNT_W-1:0]      free_cnt_r;
  logic [INDEX_BITS-1:0] top_r;
  logic [INDEX_BITS-1:0] below_r;
  logic [INDEX_BITS-1:0] used_r;
  logic [INDEX_BITS-1:0] set_size_r;
  logic [SUBSET_COUNT-1:0] sub_vld_r;
  logic [INDEX_BITS-1:0] free_mem [FREE_DEPTH];
  logic [INDEX_BITS-1:0] sub_mem  [SUBSET_COUNT];

  // result register
  logic                  out_vld_r;
  logic [INDEX_BITS-1:0] granted_r;
  logic [INDEX_BITS-1:0] used_out_r;
  logic [INDEX_BITS-1:0] set_out_r;
  logic [INDEX_BITS-1:0] sub_out_r;
  status_t               status_r;

  // handshake and request decode
  logic                  fire;
  logic                  in_take;
  logic [EXT_W-1:0]      in_sub_ext;
  logic                  in_sub_ok;
  logic [SUB_AW-1:0]     in_sub_addr;
  logic [CNT_W-1:0]      rd_ptr;

  // single pass update
  logic [INDEX_BITS-1:0] step_ext;
  logic [INDEX_BITS:0]   set_sum;
  logic [INDEX_BITS:0]   used_sum;
  logic [INDEX_BITS:0]   sub_sum;
  logic                  pop;
  logic                  push;
  logic [INDEX_BITS-1:0] granted_nxt;
  logic [INDEX_BITS-1:0] set_size_nxt;
  logic [INDEX_BITS-1:0] used_nxt;
  logic [INDEX_BITS-1:0] sub_cnt_nxt;
  status_t               status_nxt;

  // apb register access
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_GROUPED_MODE) begin
      prdata = CFG_DW'(grouped_mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grouped_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_idx == REG_GROUPED_MODE) begin
      grouped_mode_r <= pwdata[0];
    end
  end

  // handshake
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  assign in_sub_ext  = EXT_W'(in_subset);
  assign in_sub_ok   = in_sub_ext < EXT_W'(SUBSET_COUNT);
  assign in_sub_addr = in_sub_ext[SUB_AW-1:0];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r     <= in_mode;
      sub_ok_r   <= in_sub_ok;
      sub_addr_r <= in_sub_addr;
      step_r     <= grouped_mode_r ? DOFS_W'(1) : in_dofs_per_object;
      rel_r      <= INDEX_BITS'(in_released_index);
    end
  end

  // subset counter read, forwarding the count written by the beat leaving now
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (!in_sub_ok) begin
        sub_rd_r <= '0;
      end else if (fire && sub_ok_r && sub_addr_r == in_sub_addr) begin
        sub_rd_r <= sub_cnt_nxt;
      end else if (sub_vld_r[in_sub_addr]) begin
        sub_rd_r <= sub_mem[in_sub_addr];
      end else begin
        sub_rd_r <= '0;
      end
    end
  end

  // saturating sums
  assign step_ext = INDEX_BITS'(step_r);
  assign set_sum  = {1'b0, set_size_r} + {1'b0, step_ext};
  assign used_sum = {1'b0, used_r} + {1'b0, step_ext};
  assign sub_sum  = {1'b0, sub_rd_r} + {1'b0, step_ext};

  // allocate / release update
  always_comb begin
    pop          = 1'b0;
    push         = 1'b0;
    granted_nxt  = '0;
    set_size_nxt = set_size_r;
    used_nxt     = used_r;
    sub_cnt_nxt  = sub_rd_r;
    status_nxt   = ST_OK;
    if (mode_r == MODE_ALLOC) begin
      if (free_cnt_r != '0) begin
        pop         = 1'b1;
        granted_nxt = top_r;
      end else begin
        granted_nxt = set_size_r;
        if (set_sum[INDEX_BITS]) begin
          set_size_nxt = IDX_MAX;
          status_nxt   = ST_EXHAUSTED;
        end else begin
          set_size_nxt = set_sum[INDEX_BITS-1:0];
        end
      end
      if (used_sum[INDEX_BITS]) begin
        used_nxt   = IDX_MAX;
        status_nxt = ST_EXHAUSTED;
      end else begin
        used_nxt = used_sum[INDEX_BITS-1:0];
      end
      if (sub_ok_r) begin
        if (sub_sum[INDEX_BITS]) begin
          sub_cnt_nxt = IDX_MAX;
          status_nxt  = ST_EXHAUSTED;
        end else begin
          sub_cnt_nxt = sub_sum[INDEX_BITS-1:0];
        end
      end
    end else begin
      if (step_ext > used_r) begin
        used_nxt   = '0;
        status_nxt = ST_UNDERFLOW;
      end else begin
        used_nxt = used_r - step_ext;
      end
      if (sub_ok_r) begin
        if (step_ext > sub_rd_r) begin
          sub_cnt_nxt = '0;
          status_nxt  = ST_UNDERFLOW;
        end else begin
          sub_cnt_nxt = sub_rd_r - step_ext;
        end
      end
      // a full stack drops the index and outranks underflow
      if (free_cnt_r < CNT_W'(FREE_DEPTH)) begin
        push = 1'b1;
      end else begin
        status_nxt = ST_FULL;
      end
    end
  end

  // global counters and stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= '0;
      used_r     <= '0;
      set_size_r <= '0;
    end else if (fire) begin
      used_r     <= used_nxt;
      set_size_r <= set_size_nxt;
      if (pop) begin
        free_cnt_r <= free_cnt_r - 1'b1;
      end else if (push) begin
        free_cnt_r <= free_cnt_r + 1'b1;
      end
    end
  end

  // free stack: cached top and next entry, memory holds every pushed entry
  assign rd_ptr = free_cnt_r - CNT_W'(3);

  always_ff @(posedge clk) begin
    if (fire && push) begin
      free_mem[free_cnt_r[ADDR_W-1:0]] <= rel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pop) begin
      top_r   <= below_r;
      below_r <= free_mem[rd_ptr[ADDR_W-1:0]];
    end else if (fire && push) begin
      top_r   <= rel_r;
      below_r <= top_r;
    end
  end

  // subset counters with per-entry valid bits
  always_ff @(posedge clk) begin
    if (fire && sub_ok_r) begin
      sub_mem[sub_addr_r] <= sub_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_vld_r <= '0;
    end else if (fire && sub_ok_r) begin
      sub_vld_r[sub_addr_r] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_r  <= granted_nxt;
      used_out_r <= used_nxt;
      set_out_r  <= set_size_nxt;
      sub_out_r  <= sub_ok_r ? sub_cnt_nxt : '0;
      status_r   <= status_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_granted_index = FIELD_W'(granted_r);
  assign out_used_total    = FIELD_W'(used_out_r);
  assign out_set_size      = FIELD_W'(set_out_r);
  assign out_subset_used   = FIELD_W'(sub_out_r);
  assign out_status        = status_r;

`ifndef NO_ASSERTIONS
  // stack depth never passes its capacity
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(FREE_DEPTH))
    else $error("free stack depth beyond capacity");

  // a pop from a non-empty stack lowers the depth by one
  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == MODE_ALLOC && free_cnt_r != '0 |=>
    free_cnt_r == $past(free_cnt_r) - 1'b1)
    else $error("pop did not lower stack depth");

  // the index set never shrinks
  a_set_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> set_size_r >= $past(set_size_r))
    else $error("index set size decreased");

  // a full-stack status only comes from a release, which grants nothing
  a_full_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_granted_index == '0)
    else $error("stack full status with a granted index");
`endif

endmodule
